/* hw/rtl/mvb_pkg.sv */
package mvb_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 64;
    localparam int DATA_BITS_DEF = 16;

    localparam int FRAC_SHIFT = 8;
    localparam int ACC_W      = 64;
    localparam int ROW_W      = 6;
    localparam int COL_IN_W   = 6;
    localparam int CNT_W      = 7;

    typedef enum logic [1:0] {
        ACT_WEIGHT  = 2'd0,
        ACT_BIAS    = 2'd1,
        ACT_INPUT   = 2'd2,
        ACT_COMPUTE = 2'd3
    } mvb_action_t;

    typedef enum logic [1:0] {
        REG_ROWS    = 2'd0,
        REG_COLS    = 2'd1,
        REG_BIAS_EN = 2'd2
    } mvb_reg_t;

    // One multiply-accumulate step issued by the controller.
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             row_end;
        logic             run_end;
        logic [ROW_W-1:0] row;
    } mvb_cmd_t;

endpackage

/* hw/rtl/matrix_vector_multiply_bias_core.sv */
// Load transactions (weight, bias, input element) give no result.
// A compute transaction keeps busy high through the whole run: one multiply-accumulate
// per cycle through a single multiplier, plus read, multiply, accumulate and output stages.
// Row r's result shows once its final sum has passed the accumulate and output stages, for
// one cycle, and the receiver cannot stall it; after a compute, the next waits for busy to fall.
// Reset clears control and configuration (rows 64, cols 64, bias off); stores are undefined.
module matrix_vector_multiply_bias_core #(
    parameter int MAX_ROWS  = mvb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = mvb_pkg::MAX_COLS_DEF,
    parameter int DATA_BITS = mvb_pkg::DATA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [mvb_pkg::ROW_W-1:0]     row,
    input  logic [mvb_pkg::COL_IN_W-1:0]  col,
    input  logic signed [DATA_BITS-1:0]   value,
    output logic signed [DATA_BITS-1:0]   result,
    output logic [mvb_pkg::ROW_W-1:0]     out_row,
    output logic                          saturated,
    output logic                          last,
    output logic                          result_strobe,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mvb_pkg::*;

    localparam int WA_W   = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    logic              bias_en_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    logic              accept;
    logic              run_done;
    mvb_cmd_t          cmd;
    logic [WA_W-1:0]   w_addr;
    logic [COL_W-1:0]  x_addr;
    logic [ROW_AW-1:0] b_addr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign accept  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= CNT_W'(64);
            cols_reg    <= CNT_W'(64);
            bias_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ROWS:    rows_reg    <= pwdata[CNT_W-1:0];
                REG_COLS:    cols_reg    <= pwdata[CNT_W-1:0];
                REG_BIAS_EN: bias_en_reg <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROWS:    prdata = 32'(rows_reg);
            REG_COLS:    prdata = 32'(cols_reg);
            REG_BIAS_EN: prdata = 32'(bias_en_reg);
            default:     prdata = '0;
        endcase
    end

    mvb_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .run_done    (run_done),
        .busy        (busy),
        .cmd         (cmd),
        .w_addr      (w_addr),
        .x_addr      (x_addr),
        .b_addr      (b_addr)
    );

    mvb_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .action        (action),
        .row           (row),
        .col           (col),
        .value         (value),
        .bias_en       (bias_en_reg),
        .cmd           (cmd),
        .w_addr        (w_addr),
        .x_addr        (x_addr),
        .b_addr        (b_addr),
        .run_done      (run_done),
        .result        (result),
        .out_row       (out_row),
        .saturated     (saturated),
        .last          (last),
        .result_strobe (result_strobe)
    );

    // Results only appear inside a compute run.
    assert property (@(posedge clk) disable iff (!rst_n) result_strobe |-> busy)
        else $error("result strobe outside a compute run");

    // The final result of a run ends the run.
    assert property (@(posedge clk) disable iff (!rst_n) result_strobe && last |=> !busy)
        else $error("busy held after the final result");

    // Only an accepted compute transaction starts a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action == ACT_COMPUTE))
        else $error("busy rose without a compute transaction");

endmodule

/* hw/rtl/mvb_ctrl.sv */
module mvb_ctrl #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    localparam int WA_W   = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [1:0]              action,
    input  logic [mvb_pkg::CNT_W-1:0] rows_in_use,
    input  logic [mvb_pkg::CNT_W-1:0] cols_in_use,
    input  logic                    run_done,
    output logic                    busy,
    output mvb_pkg::mvb_cmd_t       cmd,
    output logic [WA_W-1:0]         w_addr,
    output logic [COL_W-1:0]        x_addr,
    output logic [ROW_AW-1:0]       b_addr
);
    import mvb_pkg::*;

    localparam int CW = (COL_W + 1 > CNT_W) ? COL_W + 1 : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t               state_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [WA_W-1:0]      base_reg;
    logic [ROW_W-1:0]     nr_m1_reg;
    logic [COL_W-1:0]     nc_m1_reg;
    logic [ROW_W-1:0]     nr_m1_next;
    logic [COL_W-1:0]     nc_m1_next;
    logic [CNT_W-1:0]     nr;
    logic [CW-1:0]        nc;
    logic [CW-1:0]        cols_ext;
    logic                 col_wrap;
    logic                 row_wrap;

    // Zero counts act as one, counts above the array size act as the size.
    always_comb
    begin
        cols_ext = CW'(cols_in_use);
        priority if (rows_in_use == '0)
            nr = CNT_W'(1);
        else if (rows_in_use > CNT_W'(MAX_ROWS))
            nr = CNT_W'(MAX_ROWS);
        else
            nr = rows_in_use;
        priority if (cols_ext == '0)
            nc = CW'(1);
        else if (cols_ext > CW'(MAX_COLS))
            nc = CW'(MAX_COLS);
        else
            nc = cols_ext;
        nr_m1_next = ROW_W'(nr - CNT_W'(1));
        nc_m1_next = COL_W'(nc - CW'(1));
    end

    assign col_wrap = (col_reg == nc_m1_reg);
    assign row_wrap = (row_reg == nr_m1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            nr_m1_reg <= '0;
            nc_m1_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && action == ACT_COMPUTE)
                    begin
                        state_reg <= S_RUN;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        base_reg  <= '0;
                        nr_m1_reg <= nr_m1_next;
                        nc_m1_reg <= nc_m1_next;
                    end
                end
                S_RUN:
                begin
                    if (col_wrap)
                    begin
                        col_reg  <= '0;
                        row_reg  <= row_reg + ROW_W'(1);
                        base_reg <= base_reg + WA_W'(MAX_COLS);
                        if (row_wrap)
                            state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (run_done)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.issue   = (state_reg == S_RUN);
    assign cmd.first   = (col_reg == '0);
    assign cmd.row_end = col_wrap;
    assign cmd.run_end = col_wrap && row_wrap;
    assign cmd.row     = row_reg;
    assign w_addr      = base_reg + WA_W'(col_reg);
    assign x_addr      = col_reg;
    assign b_addr      = ROW_AW'(row_reg);

endmodule

/* hw/rtl/mvb_datapath.sv */
module mvb_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int DATA_BITS = 16,
    localparam int WA_W   = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    action,
    input  logic [mvb_pkg::ROW_W-1:0]     row,
    input  logic [mvb_pkg::COL_IN_W-1:0]  col,
    input  logic signed [DATA_BITS-1:0]   value,
    input  logic                          bias_en,
    input  mvb_pkg::mvb_cmd_t             cmd,
    input  logic [WA_W-1:0]               w_addr,
    input  logic [COL_W-1:0]              x_addr,
    input  logic [ROW_AW-1:0]             b_addr,
    output logic                          run_done,
    output logic signed [DATA_BITS-1:0]   result,
    output logic [mvb_pkg::ROW_W-1:0]     out_row,
    output logic                          saturated,
    output logic                          last,
    output logic                          result_strobe
);
    import mvb_pkg::*;

    localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int PROD_W  = 2 * DATA_BITS;

    logic [DATA_BITS-1:0] w_mem [W_DEPTH];
    logic [DATA_BITS-1:0] x_mem [MAX_COLS];
    logic [DATA_BITS-1:0] b_mem [MAX_ROWS];

    logic                 row_ok;
    logic                 col_ok;
    logic [WA_W-1:0]      wr_addr;

    logic signed [DATA_BITS-1:0] w_rd_reg;
    logic signed [DATA_BITS-1:0] x_rd_reg;
    logic signed [DATA_BITS-1:0] b_rd_reg;
    mvb_cmd_t                    s1_reg;

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [DATA_BITS-1:0] b_s2_reg;
    mvb_cmd_t                    s2_reg;

    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     bias_term;
    logic                        fin_reg;
    logic                        fin_last_reg;
    logic [ROW_W-1:0]            fin_row_reg;

    logic signed [ACC_W-1:0]     shifted;
    logic [ACC_W-DATA_BITS:0]    upper;
    logic                        fits;
    logic signed [DATA_BITS-1:0] sat_value;

    logic signed [DATA_BITS-1:0] result_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic                        sat_reg;
    logic                        last_reg;
    logic                        strobe_reg;

    assign row_ok  = (32'(row) < 32'(MAX_ROWS));
    assign col_ok  = (32'(col) < 32'(MAX_COLS));
    assign wr_addr = WA_W'(32'(row) * 32'(MAX_COLS) + 32'(col));

    // Store writes; out-of-range indexes are dropped.
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_WEIGHT && row_ok && col_ok)
            w_mem[wr_addr] <= value;
        if (accept && action == ACT_BIAS && row_ok)
            b_mem[ROW_AW'(row)] <= value;
        if (accept && action == ACT_INPUT && col_ok)
            x_mem[COL_W'(col)] <= value;
    end

    always_ff @(posedge clk)
    begin
        w_rd_reg <= w_mem[w_addr];
        x_rd_reg <= x_mem[x_addr];
        b_rd_reg <= b_mem[b_addr];
        prod_reg <= w_rd_reg * x_rd_reg;
        b_s2_reg <= b_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= cmd;
            s2_reg <= s1_reg;
        end
    end

    // The accumulator starts each row from the scaled bias, or from zero.
    always_comb
    begin
        bias_term = bias_en ? (ACC_W'(b_s2_reg) <<< FRAC_SHIFT) : '0;
        acc_next  = (s2_reg.first ? bias_term : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_reg.issue)
            acc_reg <= acc_next;
        fin_last_reg <= s2_reg.run_end;
        fin_row_reg  <= s2_reg.row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= 1'b0;
        else
            fin_reg <= s2_reg.issue && s2_reg.row_end;
    end

    always_comb
    begin
        shifted   = acc_reg >>> FRAC_SHIFT;
        upper     = shifted[ACC_W-1:DATA_BITS-1];
        fits      = (&upper) || !(|upper);
        sat_value = shifted[ACC_W-1] ? {1'b1, {(DATA_BITS-1){1'b0}}}
                                     : {1'b0, {(DATA_BITS-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (fin_reg)
        begin
            result_reg  <= fits ? shifted[DATA_BITS-1:0] : sat_value;
            sat_reg     <= !fits;
            out_row_reg <= fin_row_reg;
            last_reg    <= fin_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= fin_reg;
    end

    assign result        = result_reg;
    assign out_row       = out_row_reg;
    assign saturated     = sat_reg;
    assign last          = last_reg;
    assign result_strobe = strobe_reg;
    assign run_done      = strobe_reg && last_reg;

endmodule

/* tb/sv/dense_layer_checker.sv */
module dense_layer_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic [1:0]                              action,
    input  logic [mvb_pkg::ROW_W-1:0]               row,
    input  logic [mvb_pkg::COL_IN_W-1:0]            col,
    input  logic signed [mvb_pkg::DATA_BITS_DEF-1:0] value,
    input  logic signed [mvb_pkg::DATA_BITS_DEF-1:0] result,
    input  logic [mvb_pkg::ROW_W-1:0]               out_row,
    input  logic                                    saturated,
    input  logic                                    last,
    input  logic                                    result_strobe,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [3:0]                              paddr,
    input  logic [31:0]                             pwdata,
    input  logic [31:0]                             prdata,
    input  logic                                    pready,
    output int                                      errors,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mvb_pkg::*;

    localparam int DW = DATA_BITS_DEF;

    typedef struct {
        logic signed [DW-1:0] sum;
        logic [ROW_W-1:0]     row_idx;
        logic                 sat;
        logic                 last_row;
    } row_sum_t;

    logic signed [DW-1:0] weight_mem [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic signed [DW-1:0] bias_mem [MAX_ROWS_DEF];
    logic signed [DW-1:0] vec_mem [MAX_COLS_DEF];
    logic [CNT_W-1:0]     rows_cfg;
    logic [CNT_W-1:0]     cols_cfg;
    logic                 bias_on;
    row_sum_t             expected_rows [$];

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        errors++;
    endtask

    // Full-precision dot product, optional bias in Q16.16, floor shift and clip.
    function automatic row_sum_t dense_row(input int r, input int nc, input bit is_last);
        longint   acc;
        longint   hi;
        longint   lo;
        row_sum_t res;
        acc = 0;
        for (int c = 0; c < nc; c++)
            acc += longint'(weight_mem[r][c]) * longint'(vec_mem[c]);
        if (bias_on)
            acc += longint'(bias_mem[r]) * 256;
        acc = acc >>> FRAC_SHIFT;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        res.sat = 1'b0;
        if (acc > hi)
        begin
            acc = hi;
            res.sat = 1'b1;
        end
        if (acc < lo)
        begin
            acc = lo;
            res.sat = 1'b1;
        end
        res.sum = acc[DW-1:0];
        res.row_idx = r[ROW_W-1:0];
        res.last_row = is_last;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        row_sum_t    want;
        int          nr;
        int          nc;
        logic [31:0] readback;
        if (!rst_n)
        begin
            rows_cfg = CNT_W'(MAX_ROWS_DEF);
            cols_cfg = CNT_W'(MAX_COLS_DEF);
            bias_on = 1'b0;
            expected_rows.delete();
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_rows.size() == 0)
                    flag_mismatch($sformatf("result for row %0d with none outstanding", out_row));
                else
                begin
                    want = expected_rows.pop_front();
                    if (result !== want.sum)
                        flag_mismatch($sformatf("row %0d result %0d, want %0d",
                                                want.row_idx, result, want.sum));
                    if (out_row !== want.row_idx)
                        flag_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row_idx));
                    if (saturated !== want.sat)
                        flag_mismatch($sformatf("row %0d saturated %b, want %b",
                                                want.row_idx, saturated, want.sat));
                    if (last !== want.last_row)
                        flag_mismatch($sformatf("row %0d last %b, want %b",
                                                want.row_idx, last, want.last_row));
                end
            end

            if (start && !busy)
            begin
                case (mvb_action_t'(action))
                    ACT_WEIGHT:  weight_mem[row][col] = value;
                    ACT_BIAS:    bias_mem[row] = value;
                    ACT_INPUT:   vec_mem[col] = value;
                    ACT_COMPUTE:
                    begin
                        // Register values outside 1..MAX are clamped at use.
                        nr = (rows_cfg == 0) ? 1 :
                             (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg);
                        nc = (cols_cfg == 0) ? 1 :
                             (cols_cfg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_cfg);
                        for (int r = 0; r < nr; r++)
                            expected_rows.push_back(dense_row(r, nc, r == nr - 1));
                    end
                    default: ;
                endcase
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (mvb_reg_t'(paddr[3:2]))
                        REG_ROWS:    rows_cfg = pwdata[CNT_W-1:0];
                        REG_COLS:    cols_cfg = pwdata[CNT_W-1:0];
                        REG_BIAS_EN: bias_on = pwdata[0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (mvb_reg_t'(paddr[3:2]))
                        REG_ROWS:    readback = 32'(rows_cfg);
                        REG_COLS:    readback = 32'(cols_cfg);
                        REG_BIAS_EN: readback = 32'(bias_on);
                        default:     readback = prdata;
                    endcase
                    if (prdata !== readback)
                        flag_mismatch($sformatf("register read at 0x%0h gave 0x%0h, want 0x%0h",
                                                paddr, prdata, readback));
                end
            end
            pending = expected_rows.size();
        end
    end

endmodule

/* tb/sv/matrix_vector_multiply_bias_core_tb.sv */
module matrix_vector_multiply_bias_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = mvb_pkg::MAX_ROWS_DEF;
    localparam int NCOLS = mvb_pkg::MAX_COLS_DEF;
    localparam int ROW_BITS = mvb_pkg::ROW_W;
    localparam int COL_BITS = mvb_pkg::COL_IN_W;
    localparam int QUIET_LIMIT = 2000;

    typedef logic signed [mvb_pkg::DATA_BITS_DEF-1:0] q8_8_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    mvb_pkg::mvb_action_t             action = mvb_pkg::ACT_WEIGHT;
    logic [mvb_pkg::ROW_W-1:0]        row = '0;
    logic [mvb_pkg::COL_IN_W-1:0]     col = '0;
    q8_8_t                            value = '0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [3:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;

    logic                             busy;
    q8_8_t                            result;
    logic [mvb_pkg::ROW_W-1:0]        out_row;
    logic                             saturated;
    logic                             last;
    logic                             result_strobe;
    logic [31:0]                      prdata;
    logic                             pready;

    int errors;
    int pending;
    int quiet_cycles = 0;

    // Stimulus bookkeeping: the active region and which store entries hold data.
    int idle_pct = 0;
    int rows_now = NROWS;
    int cols_now = NCOLS;
    bit bias_now = 1'b0;
    bit w_done [NROWS][NCOLS];
    bit b_done [NROWS];
    bit x_done [NCOLS];
    int random_items = 0;
    int idle_plan [4] = '{0, 53, 0, 11};

    always #4 clk = ~clk;

    matrix_vector_multiply_bias_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .row           (row),
        .col           (col),
        .value         (value),
        .result        (result),
        .out_row       (out_row),
        .saturated     (saturated),
        .last          (last),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dense_layer_checker dense_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .row           (row),
        .col           (col),
        .value         (value),
        .result        (result),
        .out_row       (out_row),
        .saturated     (saturated),
        .last          (last),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int eff_count(input int raw, input int limit);
        if (raw == 0)
            return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function automatic q8_8_t pick_value();
        int v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(1023) - 512;
            2:
            begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom_range(16383) - 8192;
        endcase
        return v[mvb_pkg::DATA_BITS_DEF-1:0];
    endfunction

    // Holds the transaction until busy is low at a rising edge. While idling, the
    // fields carry noise with start low.
    task automatic send_item(input mvb_pkg::mvb_action_t a, input int r, input int c,
                             input q8_8_t v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            action <= mvb_pkg::mvb_action_t'($urandom_range(3));
            row <= ROW_BITS'($urandom_range(63));
            col <= COL_BITS'($urandom_range(63));
            value <= pick_value();
            @(negedge clk);
        end
        start <= 1'b1;
        action <= a;
        row <= r[mvb_pkg::ROW_W-1:0];
        col <= c[mvb_pkg::COL_IN_W-1:0];
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic load(input mvb_pkg::mvb_action_t a, input int r, input int c,
                        input q8_8_t v);
        send_item(a, r, c, v);
        case (a)
            mvb_pkg::ACT_WEIGHT: w_done[r][c] = 1'b1;
            mvb_pkg::ACT_BIAS:   b_done[r] = 1'b1;
            mvb_pkg::ACT_INPUT:  x_done[c] = 1'b1;
            default: ;
        endcase
    endtask

    // A compute must never read a store entry that was not loaded.
    task automatic compute();
        for (int r = 0; r < rows_now; r++)
        begin
            if (bias_now && !b_done[r])
                load(mvb_pkg::ACT_BIAS, r, $urandom_range(63), pick_value());
            for (int c = 0; c < cols_now; c++)
                if (!w_done[r][c])
                    load(mvb_pkg::ACT_WEIGHT, r, c, pick_value());
        end
        for (int c = 0; c < cols_now; c++)
            if (!x_done[c])
                load(mvb_pkg::ACT_INPUT, $urandom_range(63), c, pick_value());
        send_item(mvb_pkg::ACT_COMPUTE, $urandom_range(63), $urandom_range(63), pick_value());
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input mvb_pkg::mvb_reg_t idx,
                              input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are random so that the register masks get exercised.
    task automatic configure(input int rows_raw, input int cols_raw, input bit bias);
        settle();
        apb_access(1'b1, mvb_pkg::REG_ROWS, ($urandom & ~32'h7F) | 32'(rows_raw));
        apb_access(1'b1, mvb_pkg::REG_COLS, ($urandom & ~32'h7F) | 32'(cols_raw));
        apb_access(1'b1, mvb_pkg::REG_BIAS_EN, ($urandom & ~32'h1) | 32'(bias));
        apb_access(1'b0, mvb_pkg::REG_ROWS, $urandom);
        apb_access(1'b0, mvb_pkg::REG_COLS, $urandom);
        apb_access(1'b0, mvb_pkg::REG_BIAS_EN, $urandom);
        rows_now = eff_count(rows_raw, NROWS);
        cols_now = eff_count(cols_raw, NCOLS);
        bias_now = bias;
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 55)
                load(mvb_pkg::mvb_action_t'($urandom_range(2)), $urandom_range(rows_now - 1),
                     $urandom_range(cols_now - 1), pick_value());
            else if (k < 70)
                load(mvb_pkg::mvb_action_t'($urandom_range(2)), $urandom_range(63),
                     $urandom_range(63), pick_value());
            else
                compute();
            random_items++;
        end
        compute();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extreme operands, positive saturation, far corners of the stores.
        configure(2, 2, 1'b1);
        load(mvb_pkg::ACT_WEIGHT, 0, 0, 32767);
        load(mvb_pkg::ACT_WEIGHT, 0, 1, -32768);
        load(mvb_pkg::ACT_WEIGHT, 1, 0, -32768);
        load(mvb_pkg::ACT_WEIGHT, 1, 1, -32768);
        load(mvb_pkg::ACT_INPUT, 0, 0, 32767);
        load(mvb_pkg::ACT_INPUT, 63, 1, -32768);
        load(mvb_pkg::ACT_BIAS, 0, 63, -32768);
        load(mvb_pkg::ACT_BIAS, 1, 0, 32767);
        load(mvb_pkg::ACT_WEIGHT, 63, 63, -21846);
        load(mvb_pkg::ACT_BIAS, 63, 0, 21845);
        load(mvb_pkg::ACT_INPUT, 0, 63, -1);
        compute();
        // Small negative sums where the floor shift and the clip to the minimum matter.
        load(mvb_pkg::ACT_WEIGHT, 0, 0, 256);
        load(mvb_pkg::ACT_WEIGHT, 0, 1, -3);
        load(mvb_pkg::ACT_INPUT, 0, 0, -1);
        load(mvb_pkg::ACT_INPUT, 0, 1, 1);
        load(mvb_pkg::ACT_WEIGHT, 1, 0, 1);
        load(mvb_pkg::ACT_WEIGHT, 1, 1, 1);
        load(mvb_pkg::ACT_BIAS, 1, 0, -1);
        compute();
        configure(2, 2, 1'b0);
        compute();
        // Zero counts act as one row and one column.
        configure(0, 0, 1'b1);
        compute();

        for (int phase = 0; random_items < 140; phase++)
        begin
            idle_pct = idle_plan[phase % 4];
            configure($urandom_range(9), $urandom_range(9), 1'($urandom_range(1)));
            random_phase($urandom_range(8, 20));
        end

        // Full-size rows and columns, and counts above the maximum.
        idle_pct = 11;
        configure(64, 1, 1'b1);
        random_phase(4);
        idle_pct = 0;
        configure(1, 64, 1'b0);
        random_phase(4);
        idle_pct = 53;
        configure(127, 0, 1'b1);
        random_phase(3);
        idle_pct = 0;
        configure(0, 127, 1'b1);
        random_phase(3);

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
